### hdl/modexp_pkg.sv
package modexp_pkg;

   localparam int BASE_W = 30;
   localparam int POWER_W = 32;
   localparam int OPND_W = 31;
   localparam int PROD_W = 2 * OPND_W;
   localparam int RED_W = 32;
   localparam int EXP_BITS_DEFAULT = 32;

   localparam logic [BASE_W-1:0] PRIME = 30'd1000000007;
   localparam logic [RED_W-1:0] PRIME_RED = 32'd1000000007;
   localparam logic [RED_W-1:0] PRIME_X3 = 32'd3000000021;
   // floor(2^60 / prime), the Barrett reciprocal for a 30-bit modulus.
   localparam logic [OPND_W-1:0] BARRETT_MU = 31'd1152921496;
   localparam logic [BASE_W-1:0] ACC_ONE = 30'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BIT,
      ST_SQUARE,
      ST_MUL_GO,
      ST_MULTIPLY,
      ST_DONE
   } top_state_type;

   typedef enum logic [2:0] {
      MM_IDLE,
      MM_QEST,
      MM_QP,
      MM_SUB,
      MM_FIX
   } mm_state_type;

   typedef struct packed {
      logic              start;
      logic [BASE_W-1:0] a;
      logic [BASE_W-1:0] b;
   } mm_req_type;

   typedef struct packed {
      logic              done;
      logic [BASE_W-1:0] result;
   } mm_rsp_type;

endpackage

### hdl/modexp_req_if.sv
interface modexp_req_if import modexp_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [BASE_W-1:0]  base_value;
   logic [POWER_W-1:0] power;

   modport source (output valid, output base_value, output power, input ready);
   modport sink (input valid, input base_value, input power, output ready);
endinterface

### hdl/modexp_rsp_if.sv
interface modexp_rsp_if import modexp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BASE_W-1:0] residue;

   modport source (output valid, output residue, input ready);
   modport sink (input valid, input residue, output ready);
endinterface

### hdl/modexp_mulmod.sv
module modexp_mulmod import modexp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  mm_req_type mm_req,
   output mm_rsp_type mm_rsp
);

   mm_state_type      state_ff, state_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [RED_W-1:0]  xlow_ff, xlow_in;
   logic [RED_W-1:0]  r_ff, r_in;
   logic [OPND_W-1:0] mul_a, mul_b;
   logic [PROD_W-1:0] mul_full;

   // The one multiplier, shared by the product and both Barrett steps.
   assign mul_full = {{OPND_W{1'b0}}, mul_a} * {{OPND_W{1'b0}}, mul_b};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      xlow_ff <= xlow_in;
      r_ff <= r_in;
   end

   always_comb begin
      state_in = state_ff;
      prod_in = prod_ff;
      xlow_in = xlow_ff;
      r_in = r_ff;
      mul_a = {1'b0, mm_req.a};
      mul_b = {1'b0, mm_req.b};
      mm_rsp.done = 1'b0;
      mm_rsp.result = r_ff[BASE_W-1:0];
      case (state_ff)
         MM_IDLE: begin
            if (mm_req.start) begin
               prod_in = mul_full;
               state_in = MM_QEST;
            end
         end
         MM_QEST: begin
            // Quotient estimate from the product shifted down by 29 bits.
            mul_a = prod_ff[2*BASE_W-1:BASE_W-1];
            mul_b = BARRETT_MU;
            xlow_in = prod_ff[RED_W-1:0];
            prod_in = mul_full;
            state_in = MM_QP;
         end
         MM_QP: begin
            mul_a = prod_ff[PROD_W-1:PROD_W-OPND_W];
            mul_b = {1'b0, PRIME};
            prod_in = mul_full;
            state_in = MM_SUB;
         end
         MM_SUB: begin
            // The remainder is below three times the prime, so 32 bits suffice.
            r_in = xlow_ff - prod_ff[RED_W-1:0];
            state_in = MM_FIX;
         end
         MM_FIX: begin
            if (r_ff >= PRIME_RED) begin
               r_in = r_ff - PRIME_RED;
            end else begin
               mm_rsp.done = 1'b1;
               state_in = MM_IDLE;
            end
         end
         default: begin
            state_in = MM_IDLE;
         end
      endcase
   end

   assert property (@(posedge clock) disable iff (reset)
      mm_req.start |-> (state_ff == MM_IDLE))
      else $error("mulmod started while busy");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == MM_FIX) |-> (r_ff < PRIME_X3))
      else $error("Barrett remainder out of bound");

   assert property (@(posedge clock) disable iff (reset)
      mm_rsp.done |=> (state_ff == MM_IDLE))
      else $error("mulmod did not return to idle after done");

endmodule

### hdl/modular_exponentiation.sv
// Modular exponentiation modulo 1000000007 by left-to-right square and multiply.
// While the accumulator is still one, an exponent bit is consumed directly; otherwise it
// costs a square and, when the bit is set, a multiply, all through one shared multiplier.
// Throughput: one request at a time; the next is taken once the result is registered.
// Reset is synchronous and active high, and clears the sequencer and the result valid.
module modular_exponentiation import modexp_pkg::*; #(
   parameter int EXP_BITS = EXP_BITS_DEFAULT
) (
   input logic         clock,
   input logic         reset,
   modexp_req_if.sink   req_bus,
   modexp_rsp_if.source rsp_bus
);

   localparam int CNT_W = $clog2(EXP_BITS + 1);

   top_state_type       state_ff, state_in;
   logic [BASE_W-1:0]   acc_ff, acc_in;
   logic [BASE_W-1:0]   base_ff, base_in;
   logic [EXP_BITS-1:0] exp_ff, exp_in;
   logic [CNT_W-1:0]    left_ff, left_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [BASE_W-1:0]   residue_ff, residue_in;
   logic [EXP_BITS-1:0] exp_load;
   logic [BASE_W-1:0]   base_red;
   logic                cur_bit;
   logic                can_load;
   mm_req_type          mm_req;
   mm_rsp_type          mm_rsp;

   modexp_mulmod u_mulmod (
      .clock  (clock),
      .reset  (reset),
      .mm_req (mm_req),
      .mm_rsp (mm_rsp)
   );

   generate
      if (EXP_BITS <= POWER_W) begin : g_exp_trunc
         assign exp_load = req_bus.power[EXP_BITS-1:0];
      end else begin : g_exp_ext
         assign exp_load = {{(EXP_BITS-POWER_W){1'b0}}, req_bus.power};
      end
   endgenerate

   // A 30-bit base is below twice the prime, so one subtraction reduces it.
   assign base_red = (req_bus.base_value >= PRIME) ? (req_bus.base_value - PRIME)
                                                   : req_bus.base_value;
   assign cur_bit = exp_ff[EXP_BITS-1];
   assign can_load = !rsp_valid_ff || rsp_bus.ready;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.residue = residue_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      base_ff <= base_in;
      exp_ff <= exp_in;
      left_ff <= left_in;
      residue_ff <= residue_in;
   end

   always_comb begin
      state_in = state_ff;
      acc_in = acc_ff;
      base_in = base_ff;
      exp_in = exp_ff;
      left_in = left_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      residue_in = residue_ff;
      mm_req.start = 1'b0;
      mm_req.a = acc_ff;
      mm_req.b = acc_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               base_in = base_red;
               exp_in = exp_load;
               left_in = CNT_W'(EXP_BITS);
               acc_in = ACC_ONE;
               state_in = ST_BIT;
            end
         end
         ST_BIT: begin
            if (left_ff == '0) begin
               state_in = ST_DONE;
            end else if (acc_ff == ACC_ONE) begin
               // Squaring one gives one, and one times the base is the base.
               if (cur_bit) begin
                  acc_in = base_ff;
               end
               exp_in = exp_ff << 1;
               left_in = left_ff - CNT_W'(1);
            end else begin
               mm_req.start = 1'b1;
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            if (mm_rsp.done) begin
               acc_in = mm_rsp.result;
               if (cur_bit) begin
                  state_in = ST_MUL_GO;
               end else begin
                  exp_in = exp_ff << 1;
                  left_in = left_ff - CNT_W'(1);
                  state_in = ST_BIT;
               end
            end
         end
         ST_MUL_GO: begin
            mm_req.b = base_ff;
            mm_req.start = 1'b1;
            state_in = ST_MULTIPLY;
         end
         ST_MULTIPLY: begin
            if (mm_rsp.done) begin
               acc_in = mm_rsp.result;
               exp_in = exp_ff << 1;
               left_in = left_ff - CNT_W'(1);
               state_in = ST_BIT;
            end
         end
         ST_DONE: begin
            if (can_load) begin
               rsp_valid_in = 1'b1;
               residue_in = acc_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (acc_ff < PRIME))
      else $error("accumulator not reduced");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (residue_ff < PRIME))
      else $error("result not reduced");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BIT) |-> (left_ff <= CNT_W'(EXP_BITS)))
      else $error("bit counter beyond exponent width");

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps

module testbench import modexp_pkg::*; ();

   localparam int EXP_BITS = EXP_BITS_DEFAULT;
   localparam int RANDOM_REQUESTS = 1850;
   localparam int TAIL_CYCLES = 600;
   localparam longint LIMIT_CYCLES = 4_000_000;
   localparam logic [BASE_W-1:0] BASE_MAX = {BASE_W{1'b1}};
   localparam logic [POWER_W-1:0] POWER_MAX = {POWER_W{1'b1}};

   typedef struct packed {
      logic [BASE_W-1:0]  base_value;
      logic [POWER_W-1:0] power;
   } request_item_type;

   typedef struct packed {
      logic [BASE_W-1:0]  base_value;
      logic [POWER_W-1:0] power;
      logic [BASE_W-1:0]  residue;
   } residue_expect_type;

   logic clock;
   logic reset;

   modexp_req_if req_bus ();
   modexp_rsp_if rsp_bus ();

   modular_exponentiation #(.EXP_BITS(EXP_BITS)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   request_item_type   pending_requests[$];
   residue_expect_type expected_residues[$];
   request_item_type   next_request;

   logic   req_fire = 1'b0;
   int     total_requests = 0;
   int     requests_accepted = 0;
   int     results_received = 0;
   int     error_count = 0;
   int     unreduced_bases = 0;
   int     zero_powers = 0;
   longint cycle_count = 0;

   // Left-to-right square and multiply with 64-bit products; both operands stay
   // below the prime, so every product fits comfortably.
   function automatic logic [BASE_W-1:0] mod_power(input logic [BASE_W-1:0] base_in,
                                                   input logic [POWER_W-1:0] power_in);
      longint unsigned modulus;
      longint unsigned reduced_base;
      longint unsigned acc;
      logic            bit_set;
      modulus = longint'(PRIME_RED);
      reduced_base = longint'(base_in) % modulus;
      acc = 1;
      for (int i = EXP_BITS - 1; i >= 0; i--) begin
         bit_set = (i < POWER_W) ? power_in[i] : 1'b0;
         acc = (acc * acc) % modulus;
         if (bit_set) begin
            acc = (acc * reduced_base) % modulus;
         end
      end
      return acc[BASE_W-1:0];
   endfunction

   // Percentage of idle cycles for the current third of the run.
   function automatic int idle_pct(input int done_count, input int first_pct,
                                   input int second_pct);
      int third;
      third = (total_requests + 2) / 3;
      if (done_count < third) begin
         return first_pct;
      end else if (done_count < 2 * third) begin
         return second_pct;
      end
      return 0;
   endfunction

   task automatic add_request(input logic [BASE_W-1:0] base_in,
                              input logic [POWER_W-1:0] power_in);
      request_item_type item;
      item.base_value = base_in;
      item.power = power_in;
      pending_requests.push_back(item);
      total_requests++;
   endtask

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
                  expected_residues.size());
         $display("Verification failed");
         $finish;
      end
   end

   // Request driver: a request that is on the bus stays there until it is taken.
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (req_bus.valid && !req_fire) begin
         req_bus.valid <= 1'b1;
      end else if (pending_requests.size() != 0 &&
                   $urandom_range(0, 99) >= idle_pct(requests_accepted, 16, 84)) begin
         next_request = pending_requests.pop_front();
         req_bus.valid <= 1'b1;
         req_bus.base_value <= next_request.base_value;
         req_bus.power <= next_request.power;
      end else begin
         req_bus.valid <= 1'b0;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(0, 99) >= idle_pct(results_received, 84, 16));
      end
   end

   // Monitor: predicts each accepted request and checks each accepted result.
   always @(posedge clock) begin
      residue_expect_type want;
      req_fire <= !reset && req_bus.valid && req_bus.ready;
      if (!reset && req_bus.valid && req_bus.ready) begin
         want.base_value = req_bus.base_value;
         want.power = req_bus.power;
         want.residue = mod_power(req_bus.base_value, req_bus.power);
         expected_residues.push_back(want);
         requests_accepted++;
         if (req_bus.base_value >= PRIME) begin
            unreduced_bases++;
         end
         if (req_bus.power == '0) begin
            zero_powers++;
         end
      end
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         results_received++;
         if (expected_residues.size() == 0) begin
            error_count++;
            if (error_count <= 10) begin
               $display("Unexpected result: residue %0d with no request outstanding",
                        rsp_bus.residue);
            end
         end else begin
            want = expected_residues.pop_front();
            if (rsp_bus.residue !== want.residue) begin
               error_count++;
               if (error_count <= 10) begin
                  $display("Mismatch: %0d ^ %0d expected residue %0d, got %0d",
                           want.base_value, want.power, want.residue, rsp_bus.residue);
               end
            end
         end
      end
   end

   initial begin
      logic [BASE_W-1:0]  base_pick;
      logic [POWER_W-1:0] power_pick;
      int                 width;
      int                 choice;

      reset = 1'b1;

      // Directed requests: extremes, zero to the zero, unreduced bases, inverses.
      add_request(30'd0, 32'd0);
      add_request(30'd0, 32'd1);
      add_request(30'd0, POWER_MAX);
      add_request(30'd1, POWER_MAX);
      add_request(30'd1, 32'd0);
      add_request(PRIME - 30'd1, 32'd0);
      add_request(PRIME - 30'd1, 32'd1);
      add_request(PRIME - 30'd1, 32'd2);
      add_request(PRIME - 30'd1, POWER_MAX);
      add_request(30'd2, 32'd1000000005);
      add_request(30'd2, 32'd31);
      add_request(30'd2, 32'd32);
      add_request(BASE_MAX, 32'd1);
      add_request(PRIME, 32'd5);
      add_request(PRIME, 32'd0);
      add_request(PRIME + 30'd1, POWER_MAX);
      add_request(BASE_MAX, POWER_MAX);
      add_request(30'h2AAA_AAAA, 32'h5555_5555);
      add_request(30'h1555_5555, 32'hAAAA_AAAA);
      add_request(30'd123456789, 32'h8000_0000);
      add_request(30'd987654321, 32'h7FFF_FFFF);

      // Random requests; exponent widths vary so that short runs are common.
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         choice = int'($urandom_range(0, 99));
         if (choice < 12) begin
            base_pick = BASE_W'($urandom_range(int'(PRIME), int'(BASE_MAX)));
         end else if (choice < 20) begin
            case ($urandom_range(0, 2))
               0: base_pick = 30'd0;
               1: base_pick = 30'd1;
               default: base_pick = PRIME - 30'd1;
            endcase
         end else begin
            base_pick = BASE_W'($urandom_range(0, int'(PRIME) - 1));
         end
         width = int'($urandom_range(0, POWER_W));
         power_pick = $urandom;
         if (width < POWER_W) begin
            power_pick = power_pick & ((32'd1 << width) - 32'd1);
         end
         add_request(base_pick, power_pick);
      end

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (requests_accepted < total_requests) @(posedge clock);
      while (expected_residues.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Checked %0d results for %0d requests in %0d cycles", results_received,
               requests_accepted, cycle_count);
      $display("Covered %0d unreduced bases and %0d zero exponents, %0d errors",
               unreduced_bases, zero_powers, error_count);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
